// ----- design/sha256_block_compression_assert.svh -----
// Assertion macros for the checker file of the SHA-256 compression block.
`ifndef SHA256_BLOCK_COMPRESSION_ASSERT_SVH
`define SHA256_BLOCK_COMPRESSION_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SHACMP_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define SHACMP_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("%m: check failed");

`endif

// ----- design/shacmp_pkg.sv -----
// Package for the SHA-256 compression block: constants, types and round functions.
`default_nettype none

package shacmp_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned CHAIN_WORDS = 8;
	localparam int unsigned ROUNDS      = 64;
	localparam int unsigned QDEPTH      = 4;
	localparam int unsigned QAW         = $clog2(QDEPTH);

	localparam logic [3:0] BLK_LAST_CNT = 4'd15;
	localparam logic [5:0] RND_LAST     = 6'd63;
	localparam logic [2:0] DIG_LAST_IDX = 3'd7;

	typedef logic [WORD_W-1:0] word_t;

	// one queued message word
	typedef struct packed {
		word_t word;
		logic  blk_end;
		logic  eom;
	} qent_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PREP,
		ST_ROUND,
		ST_SUM,
		ST_OUT
	} bstate_t;

	localparam word_t IV [CHAIN_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K_TAB [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t bsig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t ssig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

// ----- design/sha256_block_compression.sv -----
// Top level of the SHA-256 block compression engine.
// Usage:
//   Slave channel takes padded message words, big-endian, one word per handshake;
//   tlast marks the word that closes the final block of a message (ignored on
//   any other word). Master channel returns the eight digest words, index 0
//   (most significant) first, index in tuser, tlast on index 7.
// Timing:
//   The round engine loads 16 words from a 4-entry queue (one per cycle while the
//   queue holds words), then runs a setup step, 64 rounds (one SHA-256 round per
//   cycle) and a fold into the chain state. No words are loaded while rounds run;
//   the source is held off once the queue fills.
//   The first digest word is registered from the chain state in the output state
//   that follows the fold, then one word per cycle while the sink takes them.
// Reset (arst_n low) empties the queue, clears the word position and loads the
//   standard initial hash values.
// A stalled sink holds the current digest word; the front keeps queuing words until
//   the queue fills, and the next block waits until the last digest word is loaded.
`default_nettype none

module sha256_block_compression (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] msg_word
	input  wire logic        s_tlast,   // end_of_message
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] digest_word
	output logic [2:0]       m_tuser,   // [2:0] digest_index
	output logic             m_tlast    // digest_last
);

	logic              push_valid;
	logic              push_ready;
	shacmp_pkg::qent_t push_data;
	logic              pop_valid;
	logic              pop_ready;
	shacmp_pkg::qent_t pop_data;

	shacmp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	shacmp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	shacmp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

// ----- design/shacmp_front.sv -----
// Front end: takes message words, counts position in the block, tags block end.
`default_nettype none

module shacmp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [31:0]        s_tdata,
	input  wire logic               s_tlast,
	output logic                    push_valid,
	input  wire logic               push_ready,
	output shacmp_pkg::qent_t       push_data
);

	logic [3:0] cnt_q;
	logic       blk_end;

	assign blk_end    = (cnt_q == shacmp_pkg::BLK_LAST_CNT);
	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	always_comb begin
		push_data.word    = s_tdata;
		push_data.blk_end = blk_end;
		// end flag only counts on the word that closes a block
		push_data.eom     = s_tlast & blk_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s_tvalid && push_ready) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

// ----- design/shacmp_fifo.sv -----
// Short word queue between the front end and the round engine.
`default_nettype none

module shacmp_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire shacmp_pkg::qent_t  push_data,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output shacmp_pkg::qent_t       pop_data
);

	shacmp_pkg::qent_t               mem_q [shacmp_pkg::QDEPTH];
	logic [shacmp_pkg::QAW:0]        wr_ptr_q;
	logic [shacmp_pkg::QAW:0]        rd_ptr_q;
	logic                            full;
	logic                            empty;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[shacmp_pkg::QAW] != rd_ptr_q[shacmp_pkg::QAW]) &&
		(wr_ptr_q[shacmp_pkg::QAW-1:0] == rd_ptr_q[shacmp_pkg::QAW-1:0]);

	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_data   = mem_q[rd_ptr_q[shacmp_pkg::QAW-1:0]];

	always_ff @(posedge clk) begin
		if (push_valid && !full) begin
			mem_q[wr_ptr_q[shacmp_pkg::QAW-1:0]] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push_valid && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ready && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/shacmp_back.sv -----
// Round engine: loads a block, runs 64 rounds, folds into chain state, emits digest after a message's final block.
`default_nettype none

module shacmp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pop_valid,
	output logic                    pop_ready,
	input  wire shacmp_pkg::qent_t  pop_data,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [31:0]             m_tdata,
	output logic [2:0]              m_tuser,
	output logic                    m_tlast
);

	shacmp_pkg::bstate_t state_q;
	shacmp_pkg::bstate_t state_d;

	shacmp_pkg::word_t   w_q     [shacmp_pkg::BLOCK_WORDS];
	shacmp_pkg::word_t   v_q     [shacmp_pkg::CHAIN_WORDS];
	shacmp_pkg::word_t   chain_q [shacmp_pkg::CHAIN_WORDS];
	shacmp_pkg::word_t   pre_q;
	logic [5:0]          rnd_q;
	logic [2:0]          idx_q;
	logic                eom_q;

	logic                out_valid_q;
	shacmp_pkg::word_t   out_word_q;
	logic [2:0]          out_idx_q;
	logic                out_last_q;

	shacmp_pkg::word_t   t1;
	shacmp_pkg::word_t   t2;
	shacmp_pkg::word_t   ch;
	shacmp_pkg::word_t   maj;
	shacmp_pkg::word_t   w_new;
	logic [5:0]          rnd_nxt;
	logic                out_load;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;
	assign m_tuser  = out_idx_q;
	assign m_tlast  = out_last_q;

	assign rnd_nxt  = rnd_q + 6'd1;
	assign out_load = (state_q == shacmp_pkg::ST_OUT) && (!out_valid_q || m_tready);

	always_comb begin
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		// pre_q already holds h + K[i] + W[i]
		t1    = pre_q + shacmp_pkg::bsig1(v_q[4]) + ch;
		t2    = shacmp_pkg::bsig0(v_q[0]) + maj;
		w_new = shacmp_pkg::ssig1(w_q[14]) + w_q[9] + shacmp_pkg::ssig0(w_q[1]) + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shacmp_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		case (state_q)
			shacmp_pkg::ST_LOAD: begin
				pop_ready = 1'b1;
				if (pop_valid && pop_data.blk_end) begin
					state_d = shacmp_pkg::ST_PREP;
				end
			end
			shacmp_pkg::ST_PREP: begin
				state_d = shacmp_pkg::ST_ROUND;
			end
			shacmp_pkg::ST_ROUND: begin
				if (rnd_q == shacmp_pkg::RND_LAST) begin
					state_d = shacmp_pkg::ST_SUM;
				end
			end
			shacmp_pkg::ST_SUM: begin
				state_d = eom_q ? shacmp_pkg::ST_OUT : shacmp_pkg::ST_LOAD;
			end
			shacmp_pkg::ST_OUT: begin
				if (out_load && idx_q == shacmp_pkg::DIG_LAST_IDX) begin
					state_d = shacmp_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = shacmp_pkg::ST_LOAD;
			end
		endcase
	end

	// message window: w_q[0] is the schedule word of the current round
	always_ff @(posedge clk) begin
		if ((state_q == shacmp_pkg::ST_LOAD && pop_valid) ||
			state_q == shacmp_pkg::ST_ROUND) begin
			for (int j = 0; j < shacmp_pkg::BLOCK_WORDS - 1; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[shacmp_pkg::BLOCK_WORDS-1] <=
				(state_q == shacmp_pkg::ST_ROUND) ? w_new : pop_data.word;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			shacmp_pkg::ST_PREP: begin
				for (int j = 0; j < shacmp_pkg::CHAIN_WORDS; j++) begin
					v_q[j] <= chain_q[j];
				end
				pre_q <= chain_q[7] + shacmp_pkg::K_TAB[0] + w_q[0];
			end
			shacmp_pkg::ST_ROUND: begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				// next round's h is today's g
				pre_q  <= v_q[6] + shacmp_pkg::K_TAB[rnd_nxt] + w_q[1];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < shacmp_pkg::CHAIN_WORDS; j++) begin
				chain_q[j] <= shacmp_pkg::IV[j];
			end
			rnd_q <= '0;
			idx_q <= '0;
			eom_q <= 1'b0;
		end else begin
			case (state_q)
				shacmp_pkg::ST_LOAD: begin
					if (pop_valid && pop_data.blk_end) begin
						eom_q <= pop_data.eom;
					end
				end
				shacmp_pkg::ST_PREP: begin
					rnd_q <= '0;
				end
				shacmp_pkg::ST_ROUND: begin
					rnd_q <= rnd_nxt;
				end
				shacmp_pkg::ST_SUM: begin
					for (int j = 0; j < shacmp_pkg::CHAIN_WORDS; j++) begin
						chain_q[j] <= chain_q[j] + v_q[j];
					end
					idx_q <= '0;
				end
				shacmp_pkg::ST_OUT: begin
					if (out_load) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == shacmp_pkg::DIG_LAST_IDX) begin
							for (int j = 0; j < shacmp_pkg::CHAIN_WORDS; j++) begin
								chain_q[j] <= shacmp_pkg::IV[j];
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= chain_q[idx_q];
			out_idx_q  <= idx_q;
			out_last_q <= (idx_q == shacmp_pkg::DIG_LAST_IDX);
		end
	end

endmodule

`default_nettype wire

// ----- design/shacmp_checker.sv -----
// Port-level checks for the SHA-256 compression block, bound to the top level.
`default_nettype none
`include "sha256_block_compression_assert.svh"

module shacmp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	logic [35:0] out_bus;
	logic        out_acc;

	assign out_bus = {m_tlast, m_tuser, m_tdata};
	assign out_acc = m_tvalid && m_tready;

	// stalled digest word must hold
	`SHACMP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_bus))

	// last flag goes with the final index only
	`SHACMP_ASSERT_NOW(a_last_idx, m_tvalid, m_tlast == (m_tuser == shacmp_pkg::DIG_LAST_IDX))

	// digest words leave back to back in index order
	`SHACMP_ASSERT_NEXT(a_idx_seq, out_acc && !m_tlast, m_tvalid && (m_tuser == 3'($past(m_tuser) + 3'd1)))

	// a word shown right after the final one opens the next digest
	`SHACMP_ASSERT_NEXT(a_gap_after_last, out_acc && m_tlast, !m_tvalid || (m_tuser == '0))

endmodule

bind sha256_block_compression shacmp_checker u_shacmp_checker (.*);

`default_nettype wire
